// File: sv/stp_pkg.sv
// sprite tile placement package: controller/datapath types, codes, grid tables
// used by every module of the block; no dependencies
`default_nettype none
package stp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_Y,
    ST_DIV_X,
    ST_SETUP,
    ST_EMIT
  } state_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_OFFSET_X  = 3'd0,
    REG_OFFSET_Y  = 3'd1,
    REG_DISPLAY   = 3'd2,
    REG_WRAP      = 3'd3,
    REG_DX        = 3'd4,
    REG_DY        = 3'd5,
    REG_SHADOW    = 3'd6,
    REG_PRIORITY  = 3'd7
  } reg_index_t;

  // draw kinds
  localparam logic [1:0] KIND_UNZOOMED = 2'd0;
  localparam logic [1:0] KIND_ZOOMED   = 2'd1;
  localparam logic [1:0] KIND_SHADOW   = 2'd2;
  localparam logic [1:0] KIND_WHOLE    = 2'd3;

  localparam logic [9:0]  UNITY_ZOOM = 10'h040;
  localparam logic [22:0] RECIP_NUM  = 23'h400000;
  localparam logic [23:0] RECIP_MAX  = 24'h800000;
  localparam int          DIV_STEPS  = 23;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic start_div;
    logic div_sel_x;
    logic latch_zy;
    logic latch_zx;
    logic setup;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic keep;
    logic div_done;
    logic out_free;
    logic last_tile;
  } status_t;

  function automatic logic [5:0] x_grid(input logic [2:0] i);
    logic [5:0] g;
    begin
      g = {1'b0, i[2], 1'b0, i[1], 1'b0, i[0]};
      return g;
    end
  endfunction

  function automatic logic [5:0] y_grid(input logic [2:0] i);
    logic [5:0] g;
    begin
      g = {i[2], 1'b0, i[1], 1'b0, i[0], 1'b0};
      return g;
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/stp_sprite_if.sv
// sprite attribute input channel
// valid/ready with one sprite's resolved attributes as payload
`default_nettype none
interface stp_sprite_if;
  logic               valid;
  logic               ready;
  logic [15:0]        attr_word;
  logic [23:0]        tile_code;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_x;
  logic [9:0]         zoom_y_raw;
  logic [9:0]         zoom_x_raw;
  logic [15:0]        extra_attr;
  logic signed [31:0] resolved_color;
  logic [7:0]         sprite_priority;

  modport source (output valid, attr_word, tile_code, pos_y, pos_x, zoom_y_raw,
                  zoom_x_raw, extra_attr, resolved_color, sprite_priority,
                  input ready);
  modport sink (input valid, attr_word, tile_code, pos_y, pos_x, zoom_y_raw,
                zoom_x_raw, extra_attr, resolved_color, sprite_priority,
                output ready);
endinterface
`default_nettype wire

// File: sv/stp_cmd_if.sv
// tile draw command output channel
// valid/ready with one tile command as payload
`default_nettype none
interface stp_cmd_if;
  logic               valid;
  logic               ready;
  logic [23:0]        out_code;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic [11:0]        tile_width;
  logic [11:0]        tile_height;
  logic               flip_x;
  logic               flip_y;
  logic [15:0]        palette;
  logic [1:0]         draw_kind;
  logic               highlight;
  logic               last;

  modport source (output valid, out_code, screen_x, screen_y, tile_width,
                  tile_height, flip_x, flip_y, palette, draw_kind, highlight,
                  last, input ready);
  modport sink (input valid, out_code, screen_x, screen_y, tile_width,
                tile_height, flip_x, flip_y, palette, draw_kind, highlight,
                last, output ready);
endinterface
`default_nettype wire

// File: sv/stp_cfg_if.sv
// configuration write channel
// valid/ready with register index and write data
`default_nettype none
interface stp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/stp_div.sv
// iterative restoring divider for the zoom reciprocal, one quotient bit a cycle
// depends on stp_pkg
`default_nettype none
module stp_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [9:0]  z,
  output logic             done,
  output logic [23:0]      q
);

  logic        busy;
  logic [4:0]  cnt;
  logic [22:0] num;
  logic [9:0]  rem;
  logic [22:0] quo;
  logic [9:0]  zr;
  logic [10:0] trial;
  logic        take;

  assign trial = {rem, num[22]};
  assign take  = trial >= {1'b0, zr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(stp_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) busy <= 1'b0;
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      num <= stp_pkg::RECIP_NUM + {14'd0, z[9:1]};
      rem <= '0;
      quo <= '0;
      zr  <= z;
    end else if (busy) begin
      num <= {num[21:0], 1'b0};
      rem <= take ? 10'(trial - {1'b0, zr}) : trial[9:0];
      quo <= {quo[21:0], take};
    end
  end

  // zero zoom word selects the maximum size
  assign q = (zr == 10'd0) ? stp_pkg::RECIP_MAX : {1'b0, quo};

endmodule
`default_nettype wire

// File: sv/stp_ctrl.sv
// sequencing state machine: load, two divisions, setup, tile emission
// depends on stp_pkg
`default_nettype none
module stp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire stp_pkg::status_t st,
  output stp_pkg::cmd_t         cmd
);

  stp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= stp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      stp_pkg::ST_IDLE:  if (in_valid) state_next = stp_pkg::ST_START;
      stp_pkg::ST_START: state_next = st.keep ? stp_pkg::ST_DIV_Y : stp_pkg::ST_IDLE;
      stp_pkg::ST_DIV_Y: if (st.div_done) state_next = stp_pkg::ST_DIV_X;
      stp_pkg::ST_DIV_X: if (st.div_done) state_next = stp_pkg::ST_SETUP;
      stp_pkg::ST_SETUP: state_next = stp_pkg::ST_EMIT;
      stp_pkg::ST_EMIT:  if (st.out_free && st.last_tile) state_next = stp_pkg::ST_IDLE;
      default:           state_next = stp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      stp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      stp_pkg::ST_START: cmd.start_div = st.keep;
      stp_pkg::ST_DIV_Y: begin
        cmd.latch_zy  = st.div_done;
        cmd.start_div = st.div_done;
        cmd.div_sel_x = 1'b1;
      end
      stp_pkg::ST_DIV_X: cmd.latch_zx = st.div_done;
      stp_pkg::ST_SETUP: cmd.setup = 1'b1;
      stp_pkg::ST_EMIT:  cmd.emit = st.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/stp_datapath.sv
// datapath: config registers, sprite registers, zoom divider, placement math,
// tile walk and output register; depends on stp_pkg, stp_div and the interfaces
`default_nettype none
module stp_datapath #(
  parameter int LINE_PIXELS = 320
) (
  input  wire logic       clk,
  input  wire logic       rst,
  stp_sprite_if.sink      sprite,
  stp_cmd_if.source       cmd_out,
  stp_cfg_if.sink         cfg,
  input  wire stp_pkg::cmd_t cmd,
  output stp_pkg::status_t   st
);

  localparam logic [9:0] SW_M1 = 10'((LINE_PIXELS - 1) % 1024);

  // configuration registers
  logic [15:0] off_x, off_y;
  logic [7:0]  disp;
  logic        wrap_en;
  logic [10:0] dx, dy;
  logic [1:0]  shd_mode;
  logic [7:0]  layer_pri;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_x <= '0; off_y <= '0; disp <= '0; wrap_en <= 1'b1;
      dx <= '0; dy <= '0; shd_mode <= '0; layer_pri <= '0;
    end else if (cfg.valid) begin
      unique case (stp_pkg::reg_index_t'(cfg.index))
        stp_pkg::REG_OFFSET_X: off_x     <= cfg.data;
        stp_pkg::REG_OFFSET_Y: off_y     <= cfg.data;
        stp_pkg::REG_DISPLAY:  disp      <= cfg.data[7:0];
        stp_pkg::REG_WRAP:     wrap_en   <= cfg.data[0];
        stp_pkg::REG_DX:       dx        <= cfg.data[10:0];
        stp_pkg::REG_DY:       dy        <= cfg.data[10:0];
        stp_pkg::REG_SHADOW:   shd_mode  <= cfg.data[1:0];
        stp_pkg::REG_PRIORITY: layer_pri <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // sprite registers
  logic [15:0] r_attr, r_extra;
  logic [23:0] r_code;
  logic [15:0] r_py, r_px;
  logic [9:0]  r_zy, r_zx;
  logic [31:0] r_color;
  logic [7:0]  r_pri;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_attr  <= sprite.attr_word;
      r_code  <= sprite.tile_code;
      r_py    <= sprite.pos_y;
      r_px    <= sprite.pos_x;
      r_zy    <= sprite.zoom_y_raw;
      r_zx    <= sprite.zoom_x_raw;
      r_extra <= sprite.extra_attr;
      r_color <= sprite.resolved_color;
      r_pri   <= sprite.sprite_priority;
    end
  end

  // sprite classification
  logic       is_whole, square, half, fsx, fsy, mirx, miry;
  logic [1:0] shd_code, shadow;
  logic [9:0] zx_eff;

  assign is_whole = r_color == 32'hffff_ffff;
  assign square   = r_attr[14];
  assign half     = disp[3];
  assign fsx      = disp[0];
  assign fsy      = disp[1];
  assign mirx     = r_extra[14];
  assign miry     = r_extra[15];
  assign shd_code = r_color[29] ? r_color[21:20] : r_extra[11:10];
  assign shadow   = (!is_whole && shd_mode[0]) ? shd_code : 2'd0;
  assign zx_eff   = square ? r_zy : r_zx;
  assign st.keep  = (r_pri == layer_pri) && !(is_whole && !shd_mode[0]);

  // reciprocal divider
  logic [23:0] q, zy_q, zx_q;

  stp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_div),
    .z     (cmd.div_sel_x ? zx_eff : r_zy),
    .done  (st.div_done),
    .q     (q)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_zy) zy_q <= q;
    if (cmd.latch_zx) zx_q <= q;
  end

  // placement math, all modulo ten bits up to the final wrap
  logic signed [16:0] xv, xh;
  logic [9:0]  x10, y10, xm, ym, oy0;
  logic [23:0] zoom_x_c;
  logic [26:0] xspan, yspan;

  always_comb begin
    xv  = wrap_en ? {7'd0, r_px[9:0]} : {r_px[15], r_px};
    xh  = half ? 17'((xv >>> 1) + 17'sd1 + (fsx ? {7'd0, SW_M1} : 17'sd0)) : xv;
    x10 = fsx ? 10'(-xh[9:0]) : xh[9:0];
    x10 = 10'(x10 - off_x[9:0] + dx[9:0]);
    oy0 = fsy ? r_py[9:0] : 10'(-r_py[9:0]);
    y10 = 10'(oy0 - off_y[9:0] - dy[9:0]);
    xm  = 10'(x10 + 10'd16);
    ym  = 10'(y10 + 10'd16);
    zoom_x_c = half ? {1'b0, zx_q[23:1]} : zx_q;
    xspan = {3'd0, zoom_x_c} << r_attr[9:8];
    yspan = {3'd0, zy_q} << r_attr[11:10];
  end

  // per-sprite setup registers
  logic [23:0] zoom_x, zoom_y;
  logic [15:0] ox, oy;
  logic [1:0]  lw, lh;
  logic [2:0]  xa, ya;
  logic [17:0] base;
  logic        flipx, flipy, s_mirx, s_miry, nozoom, whole_s, shad_s, hl_s;
  logic [15:0] pal;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      zoom_x  <= zoom_x_c;
      zoom_y  <= zy_q;
      ox      <= 16'({6'd0, xm} - 16'd16 - {2'd0, xspan[26:13]});
      oy      <= 16'({6'd0, ym} - 16'd16 - {2'd0, yspan[26:13]});
      lw      <= r_attr[9:8];
      lh      <= r_attr[11:10];
      xa      <= {r_code[4], r_code[2], r_code[0]};
      ya      <= {r_code[5], r_code[3], r_code[1]};
      base    <= r_code[23:6];
      flipx   <= (r_attr[12] && !mirx) ^ (fsx && !mirx);
      flipy   <= r_attr[13] ^ (fsy && !miry);
      s_mirx  <= mirx;
      s_miry  <= miry;
      nozoom  <= !half && (zx_eff == stp_pkg::UNITY_ZOOM) && (r_zy == stp_pkg::UNITY_ZOOM);
      whole_s <= is_whole;
      shad_s  <= shadow != 2'd0;
      hl_s    <= (shd_mode == 2'd3) && (shadow == 2'd2);
      pal     <= is_whole ? 16'd0 : r_color[15:0];
    end
  end

  // tile walk counters
  logic [2:0] tx, ty;
  logic       dup;
  logic [3:0] w, h;
  logic       dupmode, tile_last;

  assign w         = 4'd1 << lw;
  assign h         = 4'd1 << lh;
  assign dupmode   = s_miry && (lh == 2'd0);
  assign tile_last = ({1'b0, tx} == 4'(w - 4'd1)) && ({1'b0, ty} == 4'(h - 4'd1));
  assign st.last_tile = tile_last && (!dupmode || dup);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      tx <= '0; ty <= '0; dup <= 1'b0;
    end else if (cmd.emit) begin
      if (dupmode && !dup) begin
        dup <= 1'b1;
      end else begin
        dup <= 1'b0;
        if ({1'b0, tx} == 4'(w - 4'd1)) begin
          tx <= '0;
          ty <= ty + 3'd1;
        end else begin
          tx <= tx + 3'd1;
        end
      end
    end
  end

  // per-tile command
  logic [2:0]  rx, nx, ry, ny;
  logic [5:0]  xg, yg;
  logic        fx, fy, c_fx, c_fy;
  logic [1:0]  kind;
  logic [27:0] px0, px1, py0, py1;
  logic [15:0] ax0, ax1, ay0, ay1;

  always_comb begin
    rx = 3'(w - 4'd1 - {1'b0, tx} + {1'b0, xa});
    nx = tx + xa;
    ry = 3'(h - 4'd1 - {1'b0, ty} + {1'b0, ya});
    ny = ty + ya;
    if (s_mirx) begin
      if (!flipx ^ ({tx, 1'b0} < w)) begin
        xg = stp_pkg::x_grid(rx); fx = 1'b1;
      end else begin
        xg = stp_pkg::x_grid(nx); fx = 1'b0;
      end
    end else begin
      xg = flipx ? stp_pkg::x_grid(rx) : stp_pkg::x_grid(nx);
      fx = flipx;
    end
    if (s_miry) begin
      if (!flipy ^ ({ty, 1'b0} >= h)) begin
        yg = stp_pkg::y_grid(ry); fy = 1'b1;
      end else begin
        yg = stp_pkg::y_grid(ny); fy = 1'b0;
      end
    end else begin
      yg = flipy ? stp_pkg::y_grid(ry) : stp_pkg::y_grid(ny);
      fy = flipy;
    end
    // first of a doubled pair carries the opposite vertical flip
    if (shad_s || whole_s) begin
      kind = whole_s ? stp_pkg::KIND_WHOLE : stp_pkg::KIND_SHADOW;
      c_fx = flipx;
      c_fy = flipy ^ (dupmode && !dup);
    end else if (nozoom) begin
      kind = stp_pkg::KIND_UNZOOMED;
      c_fx = flipx;
      c_fy = flipy ^ (dupmode && !dup);
    end else begin
      kind = stp_pkg::KIND_ZOOMED;
      c_fx = fx;
      c_fy = fy ^ (dupmode && !dup);
    end
    px0 = 28'(zoom_x) * 28'(tx) + 28'd2048;
    px1 = 28'(zoom_x) * 28'({1'b0, tx} + 4'd1) + 28'd2048;
    py0 = 28'(zoom_y) * 28'(ty) + 28'd2048;
    py1 = 28'(zoom_y) * 28'({1'b0, ty} + 4'd1) + 28'd2048;
    ax0 = px0[27:12];
    ax1 = px1[27:12];
    ay0 = py0[27:12];
    ay1 = py1[27:12];
  end

  // output register
  logic o_valid;

  assign st.out_free = !o_valid || cmd_out.ready;
  assign cmd_out.valid = o_valid;

  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (cmd.emit) o_valid <= 1'b1;
    else if (cmd_out.ready) o_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cmd_out.out_code    <= {base, 6'd0} + {18'd0, xg} + {18'd0, yg};
      cmd_out.screen_x    <= ox + ax0;
      cmd_out.screen_y    <= oy + ay0;
      cmd_out.tile_width  <= 12'(ax1 - ax0);
      cmd_out.tile_height <= 12'(ay1 - ay0);
      cmd_out.flip_x      <= c_fx;
      cmd_out.flip_y      <= c_fy;
      cmd_out.palette     <= pal;
      cmd_out.draw_kind   <= kind;
      cmd_out.highlight   <= (shad_s || whole_s) && hl_s;
      cmd_out.last        <= st.last_tile;
    end
  end

endmodule
`default_nettype wire

// File: sv/sprite_tile_placement_top.sv
// sprite tile placement: takes one sprite per transfer on the sprite channel and
// sends one draw command per 16x16 tile (two for a tile of a one-row sprite with
// y mirror) on the cmd channel; cfg writes registers 0..7 (offsets, display
// control, wrap, board adjust, shadow mode, priority). after a sprite transfer
// the block passes the start state, runs two 23-step reciprocal divisions on one
// shared divider, passes the setup state, then emits one command per cycle while
// the receiver is ready, in row order, up to 64 per sprite; the last carries
// last=1. a rejected sprite (priority mismatch, or whole shadow with shadows off)
// goes from the start state back to idle.
// the next sprite is taken as soon as the final command sits in the output
// register. a stalled receiver holds the output register and emission pauses
// without loss. reset (rst, synchronous) returns to idle with an empty output
// register and the registers at their defaults (wrap on, all else zero).
// configuration must be written only while idle, unenforced; cfg is always ready.
// depends on stp_pkg, the three channel interfaces, stp_ctrl and stp_datapath
`default_nettype none
module sprite_tile_placement_top #(
  parameter int LINE_PIXELS = 320
) (
  input  wire logic  clk,
  input  wire logic  rst,
  stp_sprite_if.sink sprite,
  stp_cmd_if.source  cmd,
  stp_cfg_if.sink    cfg
);

  stp_pkg::cmd_t    ctl;
  stp_pkg::status_t st;

  stp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sprite.valid),
    .in_ready (sprite.ready),
    .st       (st),
    .cmd      (ctl)
  );

  stp_datapath #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .sprite  (sprite),
    .cmd_out (cmd),
    .cfg     (cfg),
    .cmd     (ctl),
    .st      (st)
  );

endmodule
`default_nettype wire
